// ----- rtl/cfl_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfl_pkg
// shared constants, types and codes of the chunked free-list block allocator
// ----------------------------------------------------------------------------
package cfl_pkg;

  localparam int CHUNK_SLOTS = 8;
  localparam int MAX_BLOCKS  = 255;
  localparam int SLOT_W      = $clog2(CHUNK_SLOTS);
  localparam int BLK_W       = 8;
  localparam int HANDLE_W    = SLOT_W + BLK_W;
  localparam int CNT_W       = $clog2(CHUNK_SLOTS + 1);
  localparam int MEM_DEPTH   = CHUNK_SLOTS * (2 ** BLK_W);

  typedef logic [SLOT_W-1:0]   slot_t;
  typedef logic [BLK_W-1:0]    blk_t;
  typedef logic [CNT_W-1:0]    cnt_t;
  typedef logic [HANDLE_W-1:0] handle_t;

  typedef enum logic [1:0] {
    STAT_OK         = 2'd0,
    STAT_NO_SLOT    = 2'd1,
    STAT_BAD_HANDLE = 2'd2
  } status_t;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ACHECK,
    S_ASCAN,
    S_ANEW,
    S_AFILL,
    S_APOP,
    S_ALINK,
    S_FCHECK,
    S_FREORG,
    S_DONE
  } state_t;

  typedef struct packed {
    op_t     op;
    handle_t handle;
  } req_t;

  typedef struct packed {
    status_t status;
    handle_t handle;
  } res_t;

  // one access per cycle to the link store
  typedef struct packed {
    logic    wr_en;
    logic    rd_en;
    handle_t addr;
    blk_t    wdata;
  } link_req_t;

endpackage

// ----- rtl/cfl_link_mem.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfl_link_mem
// link store: one free-list link per block, single port, registered read
// ----------------------------------------------------------------------------
module cfl_link_mem
  import cfl_pkg::*;
(
  input  logic      clk,
  input  link_req_t req,
  output blk_t      rd_data
);

  blk_t mem [MEM_DEPTH];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.addr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data <= mem[req.addr];
    end
  end

endmodule

// ----- rtl/cfl_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfl_ctrl
// request sequencer: slot tables, chunk order and link store read-modify-write
// ----------------------------------------------------------------------------
module cfl_ctrl
  import cfl_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  blk_t      n_blocks,
  input  logic      req_valid,
  input  req_t      req,
  output logic      req_ready,
  output logic      res_valid,
  input  logic      res_ready,
  output res_t      res,
  output link_req_t link_req,
  input  blk_t      link_rdata
);

  state_t state_r, state_nxt;

  blk_t  first_free_r [CHUNK_SLOTS];
  blk_t  first_free_nxt [CHUNK_SLOTS];
  blk_t  free_count_r [CHUNK_SLOTS];
  blk_t  free_count_nxt [CHUNK_SLOTS];
  slot_t order_r [CHUNK_SLOTS];
  slot_t order_nxt [CHUNK_SLOTS];
  slot_t pos_r [CHUNK_SLOTS];
  slot_t pos_nxt [CHUNK_SLOTS];
  logic [CHUNK_SLOTS-1:0] active_r, active_nxt;
  cnt_t  in_use_r, in_use_nxt;
  cnt_t  alloc_pos_r, alloc_pos_nxt;

  handle_t handle_r, handle_nxt;
  slot_t   scan_r, scan_nxt;
  blk_t    fill_r, fill_nxt;
  slot_t   s_r, s_nxt;
  blk_t    blk_r, blk_nxt;
  res_t    res_r, res_nxt;

  // allocation lookups
  slot_t cur_slot, scan_slot, new_slot, pop_slot, last_slot;
  logic  have, scan_hit, scan_end, pool_full, fill_end;
  cnt_t  in_use_m1;

  // free lookups
  slot_t f_slot;
  blk_t  f_blk;
  logic  f_bad, f_full;

  // reorder lookups
  slot_t r_p, r_prev_slot;
  logic  r_prev_full, r_ls_full;

  assign in_use_m1 = in_use_r - cnt_t'(1);
  assign last_slot = order_r[in_use_m1[SLOT_W-1:0]];

  assign cur_slot  = order_r[alloc_pos_r[SLOT_W-1:0]];
  assign have      = (alloc_pos_r < in_use_r) && (free_count_r[cur_slot] != '0);
  assign scan_slot = order_r[scan_r];
  assign scan_hit  = free_count_r[scan_slot] != '0;
  assign scan_end  = {1'b0, scan_r} == in_use_m1;
  assign pool_full = in_use_r >= cnt_t'(CHUNK_SLOTS);
  assign fill_end  = fill_r == (n_blocks - blk_t'(1));
  assign pop_slot  = order_r[alloc_pos_r[SLOT_W-1:0]];

  // lowest inactive slot
  always_comb begin
    new_slot = '0;
    for (int i = CHUNK_SLOTS - 1; i >= 0; i--) begin
      if (!active_r[i]) new_slot = slot_t'(i);
    end
  end

  assign f_slot = handle_r[HANDLE_W-1:BLK_W];
  assign f_blk  = handle_r[BLK_W-1:0];
  assign f_bad  = !active_r[f_slot] || (f_blk >= n_blocks) ||
                  (free_count_r[f_slot] >= n_blocks);
  assign f_full = (free_count_r[f_slot] + blk_t'(1)) == n_blocks;

  assign r_p         = pos_r[s_r];
  assign r_prev_slot = order_r[r_p - slot_t'(1)];
  assign r_prev_full = free_count_r[r_prev_slot] == n_blocks;
  assign r_ls_full   = free_count_r[last_slot] == n_blocks;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (req_valid) state_nxt = (req.op == OP_FREE) ? S_FCHECK : S_ACHECK;
      end
      S_ACHECK: begin
        if (have)                   state_nxt = S_APOP;
        else if (in_use_r == '0)    state_nxt = S_ANEW;
        else                        state_nxt = S_ASCAN;
      end
      S_ASCAN: begin
        if (scan_hit)      state_nxt = S_APOP;
        else if (scan_end) state_nxt = S_ANEW;
      end
      S_ANEW: begin
        state_nxt = pool_full ? S_DONE : S_AFILL;
      end
      S_AFILL: begin
        if (fill_end) state_nxt = S_APOP;
      end
      S_APOP:  state_nxt = S_ALINK;
      S_ALINK: state_nxt = S_DONE;
      S_FCHECK: begin
        if (f_bad)       state_nxt = S_DONE;
        else if (f_full) state_nxt = S_FREORG;
        else             state_nxt = S_DONE;
      end
      S_FREORG: state_nxt = S_DONE;
      S_DONE: begin
        if (res_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    first_free_nxt = first_free_r;
    free_count_nxt = free_count_r;
    order_nxt      = order_r;
    pos_nxt        = pos_r;
    active_nxt     = active_r;
    in_use_nxt     = in_use_r;
    alloc_pos_nxt  = alloc_pos_r;
    handle_nxt     = handle_r;
    scan_nxt       = scan_r;
    fill_nxt       = fill_r;
    s_nxt          = s_r;
    blk_nxt        = blk_r;
    res_nxt        = res_r;
    link_req       = '0;
    req_ready      = 1'b0;
    res_valid      = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        req_ready  = 1'b1;
        handle_nxt = req.handle;
      end
      S_ACHECK: begin
        scan_nxt = '0;
      end
      S_ASCAN: begin
        if (scan_hit) alloc_pos_nxt = {1'b0, scan_r};
        scan_nxt = scan_r + slot_t'(1);
      end
      S_ANEW: begin
        s_nxt    = new_slot;
        fill_nxt = '0;
        if (pool_full) res_nxt = '{status: STAT_NO_SLOT, handle: '0};
      end
      S_AFILL: begin
        // link blocks 0..n-1 in sequence
        link_req.wr_en = 1'b1;
        link_req.addr  = {s_r, fill_r};
        link_req.wdata = fill_r + blk_t'(1);
        fill_nxt       = fill_r + blk_t'(1);
        if (fill_end) begin
          first_free_nxt[s_r]                    = '0;
          free_count_nxt[s_r]                    = n_blocks;
          active_nxt[s_r]                        = 1'b1;
          order_nxt[in_use_r[SLOT_W-1:0]]        = s_r;
          pos_nxt[s_r]                           = in_use_r[SLOT_W-1:0];
          alloc_pos_nxt                          = in_use_r;
          in_use_nxt                             = in_use_r + cnt_t'(1);
        end
      end
      S_APOP: begin
        s_nxt         = pop_slot;
        blk_nxt       = first_free_r[pop_slot];
        link_req.rd_en = 1'b1;
        link_req.addr  = {pop_slot, first_free_r[pop_slot]};
      end
      S_ALINK: begin
        first_free_nxt[s_r] = link_rdata;
        free_count_nxt[s_r] = free_count_r[s_r] - blk_t'(1);
        res_nxt             = '{status: STAT_OK, handle: {s_r, blk_r}};
      end
      S_FCHECK: begin
        s_nxt = f_slot;
        if (f_bad) begin
          res_nxt = '{status: STAT_BAD_HANDLE, handle: '0};
        end else begin
          link_req.wr_en         = 1'b1;
          link_req.addr          = handle_r;
          link_req.wdata         = first_free_r[f_slot];
          first_free_nxt[f_slot] = f_blk;
          free_count_nxt[f_slot] = free_count_r[f_slot] + blk_t'(1);
          res_nxt                = '{status: STAT_OK, handle: '0};
        end
      end
      S_FREORG: begin
        // chunk now wholly free: drop a free tail or move it to the end
        if (r_p == in_use_m1[SLOT_W-1:0]) begin
          if ((in_use_r > cnt_t'(1)) && r_prev_full) begin
            active_nxt[last_slot] = 1'b0;
            in_use_nxt            = in_use_m1;
            alloc_pos_nxt         = '0;
          end
        end else if (r_ls_full) begin
          active_nxt[last_slot] = 1'b0;
          in_use_nxt            = in_use_m1;
          alloc_pos_nxt         = {1'b0, r_p};
        end else begin
          order_nxt[r_p]                     = last_slot;
          pos_nxt[last_slot]                 = r_p;
          order_nxt[in_use_m1[SLOT_W-1:0]]   = s_r;
          pos_nxt[s_r]                       = in_use_m1[SLOT_W-1:0];
          alloc_pos_nxt                      = in_use_m1;
        end
      end
      S_DONE: begin
        res_valid = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign res = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      first_free_r <= '{default: '0};
      free_count_r <= '{default: '0};
      order_r      <= '{default: '0};
      pos_r        <= '{default: '0};
      active_r     <= '0;
      in_use_r     <= '0;
      alloc_pos_r  <= cnt_t'(CHUNK_SLOTS);
    end else begin
      state_r      <= state_nxt;
      first_free_r <= first_free_nxt;
      free_count_r <= free_count_nxt;
      order_r      <= order_nxt;
      pos_r        <= pos_nxt;
      active_r     <= active_nxt;
      in_use_r     <= in_use_nxt;
      alloc_pos_r  <= alloc_pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    handle_r <= handle_nxt;
    scan_r   <= scan_nxt;
    fill_r   <= fill_nxt;
    s_r      <= s_nxt;
    blk_r    <= blk_nxt;
    res_r    <= res_nxt;
  end

endmodule

// ----- rtl/chunked_free_list_block_allocator_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chunked_free_list_block_allocator_core
// block-handle allocator over a pool of chunk slots with per-chunk free lists
// ----------------------------------------------------------------------------
// in_*: one request per beat, in_tuser = op (0 allocate, 1 free), in_tdata
// carries the handle to free. out_*: one result per request, out_tuser =
// status, out_tdata = allocated handle (zero on a free or a failure).
// cfg_*: write of blocks_per_chunk, always ready; write only while idle.
// requests are handled one at a time; in_tready is high only when the
// sequencer is idle. allocation from the remembered chunk runs from accept
// through check, link store read, link update and hand-off; a scan over
// chunks looks at them one after another, and activating a new chunk
// first picks the slot, then does one link store write per block.
// a free checks the handle and writes its link, with a reorder step added
// when the chunk becomes wholly free.
// results sit in an output register; a stalled receiver holds the sequencer
// at its hand-off stage, so at most one result waits there plus one in flight.
// reset clears the slot tables and empties the pool; the link store needs no
// clearing since every link is written before it is read.
// ----------------------------------------------------------------------------
module chunked_free_list_block_allocator_core
  import cfl_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [10:0] handle
  input  logic [0:0]  in_tuser,   // [0] op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [10:0] block_handle
  output logic [1:0]  out_tuser,  // [1:0] status
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data    // [7:0] blocks_per_chunk
);

  blk_t      cfg_r;
  blk_t      n_blocks;
  req_t      req;
  res_t      res;
  logic      res_valid, res_ready;
  link_req_t link_req;
  blk_t      link_rdata;
  logic      out_valid_r, out_valid_nxt;
  res_t      out_res_r, out_res_nxt;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= blk_t'(MAX_BLOCKS);
    end else if (cfg_valid && cfg_ready) begin
      cfg_r <= cfg_data;
    end
  end

  // zero acts as one, clamp to the largest chunk
  always_comb begin
    if (cfg_r == '0)                        n_blocks = blk_t'(1);
    else if (cfg_r > blk_t'(MAX_BLOCKS))    n_blocks = blk_t'(MAX_BLOCKS);
    else                                    n_blocks = cfg_r;
  end

  assign req.op     = op_t'(in_tuser[0]);
  assign req.handle = in_tdata[HANDLE_W-1:0];

  cfl_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .n_blocks   (n_blocks),
    .req_valid  (in_tvalid),
    .req        (req),
    .req_ready  (in_tready),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res),
    .link_req   (link_req),
    .link_rdata (link_rdata)
  );

  cfl_link_mem u_link_mem (
    .clk     (clk),
    .req     (link_req),
    .rd_data (link_rdata)
  );

  // output register
  assign res_ready = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = res;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.status;
  assign out_tdata  = {{(16 - HANDLE_W){1'b0}}, out_res_r.handle};

  // one request at a time: busy right after a beat is taken
  a_busy_after_accept: assert property (
    @(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready
  ) else $error("request taken while previous one in flight");

  a_status_code: assert property (
    @(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == STAT_OK || out_tuser == STAT_NO_SLOT ||
                    out_tuser == STAT_BAD_HANDLE)
  ) else $error("undefined status code");

  a_fail_no_handle: assert property (
    @(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser != STAT_OK) |-> (out_tdata == '0)
  ) else $error("handle given with a failed result");

endmodule
